// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ESP_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Property that also holds across reset.
`define ESP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- src/esp_pkg.sv -----
package esp_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int SPEED_FRAC_BITS = 24;
  localparam int TS_W            = 32;
  localparam int TC_W            = 24;
  localparam int SPEED_W         = 32;
  localparam int STATUS_W        = 2;
  localparam int ALPHA_FRAC      = 16;
  localparam int ALPHA_W         = ALPHA_FRAC + 1;
  localparam int INST_W          = SPEED_FRAC_BITS + 1;
  localparam int ERR_W           = SPEED_W + 1;
  localparam int PROD_W          = ALPHA_W + 1 + ERR_W;

  // shared divider: 24 quotient bits max, divisor up to tau + dt (33 bits)
  localparam int QUO_W  = SPEED_FRAC_BITS;
  localparam int DVS_W  = TS_W + 1;
  localparam int CNT_W  = 5;
  localparam logic [CNT_W-1:0] INST_STEPS  = CNT_W'(QUO_W);
  localparam logic [CNT_W-1:0] ALPHA_STEPS = CNT_W'(ALPHA_W);

  localparam int QUEUE_DEPTH = 2;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic [0:0] REG_TIME_CONSTANT = 1'b0;
  localparam logic [TC_W-1:0] TC_RESET = TC_W'(1000);

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_PRIMED  = 2'd1,
    ST_BADTIME = 2'd2,
    ST_REARMED = 2'd3
  } status_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_REARM  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_INST,
    S_DIV_ALPHA,
    S_MUL,
    S_ADD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
    logic [DVS_W-1:0] rem_init;
    logic [QUO_W-1:0] dividend;  // consumed MSB first
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- src/esp_div.sv -----
// Restoring divider, one quotient bit per cycle. The partial remainder
// is preloaded so that a short quotient needs only as many steps.
module esp_div (
  input  logic              clk,
  input  logic              rst,
  input  esp_pkg::div_req_t req,
  output esp_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [esp_pkg::CNT_W-1:0]     cnt;
  logic [esp_pkg::DVS_W-1:0]     rem;
  logic [esp_pkg::DVS_W-1:0]     dvs;
  logic [esp_pkg::QUO_W-1:0]     dvd;
  logic [esp_pkg::QUO_W-1:0]     quo;
  logic [esp_pkg::DVS_W:0]       shifted;
  logic [esp_pkg::DVS_W:0]       trial;

  assign shifted = {rem, dvd[esp_pkg::QUO_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == esp_pkg::CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - esp_pkg::CNT_W'(1);
        if (cnt == esp_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      dvs <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      if (!trial[esp_pkg::DVS_W]) begin
        rem <= trial[esp_pkg::DVS_W-1:0];
        quo <= {quo[esp_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem <= shifted[esp_pkg::DVS_W-1:0];
        quo <= {quo[esp_pkg::QUO_W-2:0], 1'b0};
      end
      dvd <= {dvd[esp_pkg::QUO_W-2:0], 1'b0};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- src/esp_front.sv -----
// Input side: takes items, decodes the kind and queues them for the back end.
module esp_front #(
  parameter int ANGLE_BITS = esp_pkg::ANGLE_BITS_DEF,
  parameter int TDATA_W    = ((ANGLE_BITS + esp_pkg::TS_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [TDATA_W-1:0]       s_tdata,   // angle, timestamp, zero pad
  input  logic                     s_tuser,   // kind
  output logic                     q_valid,
  input  logic                     q_pop,
  output esp_pkg::op_t             q_op,
  output logic [ANGLE_BITS-1:0]    q_angle,
  output logic [esp_pkg::TS_W-1:0] q_time
);

  localparam int PTR_W = $clog2(esp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(esp_pkg::QUEUE_DEPTH + 1);

  esp_pkg::op_t             mem_op    [esp_pkg::QUEUE_DEPTH];
  logic [ANGLE_BITS-1:0]    mem_angle [esp_pkg::QUEUE_DEPTH];
  logic [esp_pkg::TS_W-1:0] mem_time  [esp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [CNT_W-1:0]         count;
  logic                     push;
  logic                     pop;
  esp_pkg::op_t             in_op;

  assign in_op    = s_tuser ? esp_pkg::OP_REARM : esp_pkg::OP_SAMPLE;
  assign s_tready = (count != CNT_W'(esp_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_op[wr_ptr]    <= in_op;
      mem_angle[wr_ptr] <= s_tdata[ANGLE_BITS-1:0];
      mem_time[wr_ptr]  <= s_tdata[ANGLE_BITS+esp_pkg::TS_W-1:ANGLE_BITS];
    end
  end

  assign q_op    = mem_op[rd_ptr];
  assign q_angle = mem_angle[rd_ptr];
  assign q_time  = mem_time[rd_ptr];

endmodule

// ----- src/esp_back.sv -----
// Estimator state and sequencer: priming, rearm, bad-time check, then
// speed division, weight division, multiply and accumulate.
module esp_back #(
  parameter int ANGLE_BITS = esp_pkg::ANGLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [esp_pkg::TC_W-1:0]    tau,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  esp_pkg::op_t                q_op,
  input  logic [ANGLE_BITS-1:0]       q_angle,
  input  logic [esp_pkg::TS_W-1:0]    q_time,
  output esp_pkg::div_req_t           div_req,
  input  esp_pkg::div_rsp_t           div_rsp,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [esp_pkg::SPEED_W-1:0] m_tdata,
  output logic [esp_pkg::STATUS_W-1:0] m_tuser
);

  localparam int SHIFT = esp_pkg::SPEED_FRAC_BITS - ANGLE_BITS;

  esp_pkg::state_t state;
  esp_pkg::state_t state_next;

  logic                               primed;
  logic [ANGLE_BITS-1:0]              last_angle;
  logic [esp_pkg::TS_W-1:0]           last_time;
  logic signed [esp_pkg::SPEED_W-1:0] speed_acc;

  logic [esp_pkg::TS_W-1:0]           dt;
  logic                               neg;
  logic signed [esp_pkg::ERR_W-1:0]   err;
  logic [esp_pkg::ALPHA_W-1:0]        alpha;
  logic signed [esp_pkg::PROD_W-1:0]  prod;
  logic [esp_pkg::SPEED_W-1:0]        res_speed;
  esp_pkg::status_t                   res_status;

  logic [ANGLE_BITS-1:0]              raw;
  logic [esp_pkg::QUO_W-1:0]          scaled;
  logic [esp_pkg::QUO_W-1:0]          mag;
  logic [esp_pkg::TS_W-1:0]           dt_c;
  logic                               late;
  logic                               do_update;
  logic signed [esp_pkg::INST_W-1:0]  inst_c;
  logic signed [esp_pkg::SPEED_W-1:0] speed_new;
  logic                               out_free;
  logic                               emit_load;

  // wrapped difference: MSB of raw is the sign, so half a turn reads as -half
  assign raw       = q_angle - last_angle;
  assign scaled    = esp_pkg::QUO_W'(raw) << SHIFT;
  assign mag       = raw[ANGLE_BITS-1] ? (~scaled + esp_pkg::QUO_W'(1)) : scaled;
  assign dt_c      = q_time - last_time;
  assign late      = (q_time <= last_time);
  assign do_update = (q_op == esp_pkg::OP_SAMPLE) && primed && !late;

  assign inst_c    = neg ? -$signed({1'b0, div_rsp.quotient})
                         :  $signed({1'b0, div_rsp.quotient});
  // floor(alpha*err / 2^16) is an arithmetic shift
  assign speed_new = speed_acc + prod[esp_pkg::ALPHA_FRAC+esp_pkg::SPEED_W-1:
                                      esp_pkg::ALPHA_FRAC];

  assign out_free  = !m_tvalid || m_tready;
  assign emit_load = (state == esp_pkg::S_EMIT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      esp_pkg::S_IDLE: begin
        if (q_valid) begin
          state_next = do_update ? esp_pkg::S_DIV_INST : esp_pkg::S_EMIT;
        end
      end
      esp_pkg::S_DIV_INST: begin
        if (div_rsp.done) state_next = esp_pkg::S_DIV_ALPHA;
      end
      esp_pkg::S_DIV_ALPHA: begin
        if (div_rsp.done) state_next = esp_pkg::S_MUL;
      end
      esp_pkg::S_MUL:  state_next = esp_pkg::S_ADD;
      esp_pkg::S_ADD:  state_next = esp_pkg::S_EMIT;
      esp_pkg::S_EMIT: begin
        if (out_free) state_next = esp_pkg::S_IDLE;
      end
      default: state_next = esp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    div_req = '0;
    unique case (state)
      esp_pkg::S_IDLE: begin
        q_pop            = q_valid;
        div_req.start    = q_valid && do_update;
        div_req.count    = esp_pkg::INST_STEPS;
        div_req.rem_init = '0;
        div_req.dividend = mag;
        div_req.divisor  = {1'b0, dt_c};
      end
      esp_pkg::S_DIV_INST: begin
        // dt*2^16 / (tau+dt) < 2^17: start with dt>>1 already in the remainder
        div_req.start    = div_rsp.done;
        div_req.count    = esp_pkg::ALPHA_STEPS;
        div_req.rem_init = esp_pkg::DVS_W'(dt >> 1);
        div_req.dividend = {dt[0], {(esp_pkg::QUO_W-1){1'b0}}};
        div_req.divisor  = esp_pkg::DVS_W'(tau) + esp_pkg::DVS_W'(dt);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= esp_pkg::S_IDLE;
      primed     <= 1'b0;
      last_angle <= '0;
      last_time  <= '0;
      speed_acc  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == esp_pkg::S_IDLE && q_valid) begin
        if (q_op == esp_pkg::OP_REARM) begin
          primed     <= 1'b0;
          last_angle <= '0;
          last_time  <= '0;
          speed_acc  <= '0;
        end else if (!primed || !late) begin
          primed     <= 1'b1;
          last_angle <= q_angle;
          last_time  <= q_time;
          if (!primed) begin
            speed_acc <= '0;
          end
        end
      end
      if (state == esp_pkg::S_ADD) begin
        speed_acc <= speed_new;
      end
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == esp_pkg::S_IDLE && q_valid) begin
      dt  <= dt_c;
      neg <= raw[ANGLE_BITS-1];
      priority if (q_op == esp_pkg::OP_REARM) begin
        res_speed  <= '0;
        res_status <= esp_pkg::ST_REARMED;
      end else if (!primed) begin
        res_speed  <= '0;
        res_status <= esp_pkg::ST_PRIMED;
      end else if (late) begin
        res_speed  <= speed_acc;
        res_status <= esp_pkg::ST_BADTIME;
      end else begin
        res_status <= esp_pkg::ST_UPDATED;
      end
    end
    if (state == esp_pkg::S_DIV_INST && div_rsp.done) begin
      err <= esp_pkg::ERR_W'(inst_c) - esp_pkg::ERR_W'(speed_acc);
    end
    if (state == esp_pkg::S_DIV_ALPHA && div_rsp.done) begin
      alpha <= div_rsp.quotient[esp_pkg::ALPHA_W-1:0];
    end
    if (state == esp_pkg::S_MUL) begin
      prod <= $signed({1'b0, alpha}) * err;
    end
    if (state == esp_pkg::S_ADD) begin
      res_speed <= speed_new;
    end
    if (emit_load) begin
      m_tdata <= res_speed;
      m_tuser <= res_status;
    end
  end

endmodule

// ----- src/encoder_speed_estimator.sv -----
// Encoder speed estimator. Each item carries an angle (fraction of a turn)
// and a tick timestamp, or a rearm; each item gives exactly one result with
// the filtered speed in 2^-24 turn per tick and a status. Items are queued
// (two deep) ahead of the estimator, so the input keeps accepting while a
// result waits on the output, until the queue is full. A rearm, a priming
// sample or a sample with a non-increasing timestamp goes from idle straight
// to the output state; a speed update runs the shared one-bit-per-cycle
// divider for 24 steps for the instantaneous speed and 17 steps for the
// filter weight, followed by a multiply, an accumulate and an output step.
// Output stalls hold the result in the output state. time_constant sits at
// APB address 0x0 (reset 1000 ticks); the user must write it only while the
// block is idle, which the block itself does not enforce.
module encoder_speed_estimator #(
  parameter int ANGLE_BITS = esp_pkg::ANGLE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // angle [ANGLE_BITS-1:0], timestamp [+31:ANGLE_BITS], zero pad
  input  logic [((ANGLE_BITS+esp_pkg::TS_W+7)/8)*8-1:0] s_tdata,
  input  logic                                          s_tuser,   // kind
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  output logic [esp_pkg::SPEED_W-1:0]                   m_tdata,   // speed
  output logic [esp_pkg::STATUS_W-1:0]                  m_tuser,   // status
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [esp_pkg::PADDR_W-1:0]                   paddr,
  input  logic [esp_pkg::PDATA_W-1:0]                   pwdata,
  output logic [esp_pkg::PDATA_W-1:0]                   prdata,
  output logic                                          pready
);

  localparam int TDATA_W = ((ANGLE_BITS + esp_pkg::TS_W + 7) / 8) * 8;

  logic [esp_pkg::TC_W-1:0]  time_constant;
  logic                      reg_hit;
  logic                      q_valid;
  logic                      q_pop;
  esp_pkg::op_t              q_op;
  logic [ANGLE_BITS-1:0]     q_angle;
  logic [esp_pkg::TS_W-1:0]  q_time;
  esp_pkg::div_req_t         div_req;
  esp_pkg::div_rsp_t         div_rsp;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[esp_pkg::PADDR_W-1:2] == esp_pkg::REG_TIME_CONSTANT);
  assign prdata  = reg_hit ? esp_pkg::PDATA_W'(time_constant) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_constant <= esp_pkg::TC_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      time_constant <= pwdata[esp_pkg::TC_W-1:0];
    end
  end

  esp_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .TDATA_W    (TDATA_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (q_op),
    .q_angle  (q_angle),
    .q_time   (q_time)
  );

  esp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  esp_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .tau      (time_constant),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (q_op),
    .q_angle  (q_angle),
    .q_time   (q_time),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- src/esp_checker.sv -----
`include "assert_macros.svh"

module esp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [esp_pkg::SPEED_W-1:0]         m_tdata,
  input logic [esp_pkg::STATUS_W-1:0]        m_tuser
);

  // reset leaves no result pending and the input open
  `ESP_ASSERT_ALWAYS(a_out_empty_after_rst, clk, rst |=> !m_tvalid)
  `ESP_ASSERT_ALWAYS(a_in_open_after_rst, clk, rst |=> s_tready)

  // rearm and priming always report zero speed
  `ESP_ASSERT(a_zero_speed, clk, rst,
    (m_tvalid && (m_tuser == esp_pkg::ST_REARMED || m_tuser == esp_pkg::ST_PRIMED))
      |-> (m_tdata == '0))

  `ESP_ASSERT(a_out_hold, clk, rst,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule

bind encoder_speed_estimator esp_checker u_esp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
